@@ design/ppe_pkg.sv @@
// ppe_pkg: shared widths, partition mode codes and the scan-to-output
// request struct for the pivot partition engine
// no dependencies
`default_nettype none

package ppe_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 8;
    localparam int MODE_W    = 2;

    // partition modes; the unused code behaves as the stable mode
    localparam logic [MODE_W-1:0] MODE_FIRST_REV    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIRST_STABLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LAST         = 2'd2;

    // one emitted element from the scan sequencer, or the end-of-run flush
    typedef struct packed {
        logic              vld;
        logic [DATA_W-1:0] val;
        logic              flush;
    } emit_t;

endpackage

`default_nettype wire

@@ design/ppe_ram.sv @@
// ppe_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module ppe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/ppe_scan.sv @@
// ppe_scan: sequencer that reads the pivot, then scans the element store
// twice through one shared comparator and issues emit requests
// depends on ppe_pkg
`default_nettype none

module ppe_scan #(
    parameter int DEPTH = ppe_pkg::DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             go,
    input  wire logic [ppe_pkg::MODE_W-1:0]       mode,
    input  wire logic [$clog2(DEPTH+1)-1:0]       n,
    output logic                                  rd_en,
    output logic      [$clog2(DEPTH)-1:0]         rd_addr,
    input  wire logic [ppe_pkg::DATA_W-1:0]       rd_data,
    output logic                                  busy,
    output ppe_pkg::emit_t                        emit
);

    import ppe_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PIVOT  = 3'd1;
    localparam logic [2:0] S_PLOAD  = 3'd2;
    localparam logic [2:0] S_SCAN_A = 3'd3;
    localparam logic [2:0] S_MID    = 3'd4;
    localparam logic [2:0] S_SCAN_B = 3'd5;
    localparam logic [2:0] S_FLUSH  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pend_rd_reg, pend_rd_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [DATA_W-1:0] x_reg, x_next;

    logic [CNT_W-1:0]  n_m1;
    logic [AW-1:0]     last_addr;
    logic              is_rev;
    logic              is_last_mode;
    logic              is_stable;
    logic [AW-1:0]     a_start;
    logic [AW-1:0]     b_start;
    logic [CNT_W-1:0]  scan_cnt;
    logic              lt;

    assign n_m1         = n_reg - CNT_W'(1);
    assign last_addr    = n_m1[AW-1:0];
    assign is_rev       = (mode_reg == MODE_FIRST_REV);
    assign is_last_mode = (mode_reg == MODE_LAST);
    assign is_stable    = !is_rev && !is_last_mode;
    assign a_start      = is_rev ? last_addr : '0;
    assign b_start      = is_rev ? AW'(1) : '0;
    assign scan_cnt     = is_stable ? n_reg : n_m1;

    // the shared comparator
    assign lt = (rd_data < x_reg);

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        pend_rd_next = 1'b0;
        mode_next    = mode_reg;
        n_next       = n_reg;
        x_next       = x_reg;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    mode_next  = mode;
                    n_next     = n;
                    state_next = S_PIVOT;
                end
            end
            S_PIVOT:
            begin
                rd_en      = 1'b1;
                rd_addr    = is_last_mode ? last_addr : '0;
                state_next = S_PLOAD;
            end
            S_PLOAD:
            begin
                x_next     = rd_data;
                idx_next   = a_start;
                cnt_next   = scan_cnt;
                state_next = S_SCAN_A;
            end
            S_SCAN_A:
            begin
                if (cnt_reg != '0)
                begin
                    rd_en        = 1'b1;
                    idx_next     = is_rev ? idx_reg - AW'(1) : idx_reg + AW'(1);
                    cnt_next     = cnt_reg - CNT_W'(1);
                    pend_rd_next = 1'b1;
                end
                else if (is_stable)
                begin
                    idx_next   = b_start;
                    cnt_next   = scan_cnt;
                    state_next = S_SCAN_B;
                end
                else
                begin
                    state_next = S_MID;
                end
            end
            S_MID:
            begin
                idx_next   = b_start;
                cnt_next   = scan_cnt;
                state_next = S_SCAN_B;
            end
            S_SCAN_B:
            begin
                if (cnt_reg != '0)
                begin
                    rd_en        = 1'b1;
                    idx_next     = idx_reg + AW'(1);
                    cnt_next     = cnt_reg - CNT_W'(1);
                    pend_rd_next = 1'b1;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pend_rd_reg <= 1'b0;
            cnt_reg     <= '0;
            mode_reg    <= MODE_FIRST_REV;
            n_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pend_rd_reg <= pend_rd_next;
            cnt_reg     <= cnt_next;
            mode_reg    <= mode_next;
            n_reg       <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        x_reg   <= x_next;
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        emit.vld   = ((state_reg == S_SCAN_A) && pend_rd_reg && lt)
                  || ((state_reg == S_SCAN_B) && pend_rd_reg && !lt)
                  || (state_reg == S_MID);
        emit.val   = (state_reg == S_MID) ? x_reg : rd_data;
        emit.flush = (state_reg == S_FLUSH);
    end

endmodule

`default_nettype wire

@@ design/ppe_emit.sv @@
// ppe_emit: holds the newest emitted element back one request so the final
// one can carry end_of_run, and drives the registered result ports
// depends on ppe_pkg
`default_nettype none

module ppe_emit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ppe_pkg::emit_t             emit,
    input  wire logic                       run_ovf,
    output logic                            result_valid,
    output logic [ppe_pkg::DATA_W-1:0]      elem_out,
    output logic                            end_of_run,
    output logic                            overflow
);

    import ppe_pkg::*;

    logic              pend_vld_reg, pend_vld_next;
    logic [DATA_W-1:0] pend_val_reg, pend_val_next;
    logic              out_vld_reg, out_vld_next;
    logic [DATA_W-1:0] out_val_reg;
    logic              out_end_reg;
    logic              out_ovf_reg;

    always_comb
    begin
        pend_vld_next = pend_vld_reg;
        pend_val_next = pend_val_reg;
        out_vld_next  = (emit.vld || emit.flush) && pend_vld_reg;
        if (emit.vld)
        begin
            pend_vld_next = 1'b1;
            pend_val_next = emit.val;
        end
        else if (emit.flush)
        begin
            pend_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_val_reg <= pend_val_next;
        if (out_vld_next)
        begin
            out_val_reg <= pend_val_reg;
            out_end_reg <= emit.flush;
            out_ovf_reg <= run_ovf;
        end
    end

    assign result_valid = out_vld_reg;
    assign elem_out     = out_val_reg;
    assign end_of_run   = out_end_reg;
    assign overflow     = out_ovf_reg;

endmodule

`default_nettype wire

@@ design/pivot_partition_engine.sv @@
// pivot_partition_engine: top level; element loader, mode register, store ram,
// scan sequencer and result output stage
// depends on ppe_pkg, ppe_ram, ppe_scan, ppe_emit
//
// A sequence of bytes is loaded one request per cycle (start high while busy
// is low); each is written to the element store until DEPTH are held, later
// ones are dropped and flag overflow on every result of that run. The request
// with is_last set starts the emit phase: busy rises on the next cycle, the
// pivot is read, and the store is scanned twice through one comparator, one
// element per cycle, first for the elements below the pivot, then for the
// rest. The scan is paced by the single read port of the store; results come
// as one-cycle result_valid strobes with no backpressure, so the receiver
// must take each one on the cycle it appears, and end_of_run marks the last.
// The last strobe of a run shows in the first cycle that busy is low.
// partition_mode must be written through cfg_valid (always ready) while the
// block is idle; the block itself does not enforce this.
`default_nettype none

module pivot_partition_engine #(
    parameter int DEPTH = ppe_pkg::DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [ppe_pkg::DATA_W-1:0]   value,
    input  wire logic                         is_last,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [ppe_pkg::MODE_W-1:0]   partition_mode,
    output logic                              result_valid,
    output logic      [ppe_pkg::DATA_W-1:0]   elem_out,
    output logic                              end_of_run,
    output logic                              overflow
);

    import ppe_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [MODE_W-1:0] mode_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic              run_ovf_reg, run_ovf_next;

    logic              accept;
    logic              full;
    logic              wr_en;
    logic              go;
    logic [CNT_W-1:0]  run_n;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              scan_busy;
    emit_t             emit;

    // config register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_FIRST_REV;
        end
        else if (cfg_valid)
        begin
            mode_reg <= partition_mode;
        end
    end

    // loader: store the element if there is room, else note the overflow
    assign busy   = scan_busy;
    assign accept = start && !scan_busy;
    assign full   = (count_reg >= CNT_W'(DEPTH));
    assign wr_en  = accept && !full;
    assign go     = accept && is_last;
    assign run_n  = full ? count_reg : count_reg + CNT_W'(1);

    always_comb
    begin
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        run_ovf_next = run_ovf_reg;
        if (accept)
        begin
            if (is_last)
            begin
                // the run is handed to the scan; clear for the next sequence
                count_next   = '0;
                ovf_next     = 1'b0;
                run_ovf_next = ovf_reg || full;
            end
            else
            begin
                count_next = run_n;
                ovf_next   = ovf_reg || full;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            run_ovf_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            run_ovf_reg <= run_ovf_next;
        end
    end

    // element store
    ppe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (value),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // pivot read and the two compare passes
    ppe_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go),
        .mode    (mode_reg),
        .n       (run_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .busy    (scan_busy),
        .emit    (emit)
    );

    // result strobes
    ppe_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .emit         (emit),
        .run_ovf      (run_ovf_reg),
        .result_valid (result_valid),
        .elem_out     (elem_out),
        .end_of_run   (end_of_run),
        .overflow     (overflow)
    );

endmodule

`default_nettype wire

@@ design/ppe_checker.sv @@
// ppe_checker: port-level checks of the pivot partition engine, bound to the top
// depends on ppe_pkg and pivot_partition_engine
`default_nettype none

module ppe_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       is_last,
    input wire logic                       result_valid,
    input wire logic                       end_of_run,
    input wire logic [ppe_pkg::DATA_W-1:0] elem_out
);

    // a request marked last starts the emit phase
    a_last_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && is_last |=> busy)
        else $error("busy not raised after last request");

    // results only appear during a run or right after it
    a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy || $past(busy))
        else $error("result strobe outside a run");

    // no result strobe follows right after the end of run
    a_end_with_valid: assert property (@(posedge clk) disable iff (!rst_n)
        end_of_run && result_valid |=> !result_valid)
        else $error("result strobe right after end of run");

    // a run never ends while the block is still busy
    a_end_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && end_of_run |-> !busy)
        else $error("end of run while busy");

    // a result strobe carries a known element
    a_elem_known: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !$isunknown(elem_out))
        else $error("unknown element on a result strobe");

endmodule

bind pivot_partition_engine ppe_checker u_ppe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .is_last      (is_last),
    .result_valid (result_valid),
    .end_of_run   (end_of_run),
    .elem_out     (elem_out)
);

`default_nettype wire

@@ bench/pivot_partition_engine_tb.sv @@
// pivot_partition_engine_tb: self-checking bench for the pivot partition engine,
// a directed request table, then random runs across all modes and sender gap phases
// depends on ppe_pkg and pivot_partition_engine
module pivot_partition_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppe_pkg::*;

    localparam int STORE_DEPTH = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_LIMIT = 4000;
    localparam int SEG_ITEMS   = 6;
    localparam int NUM_SEGS    = 8;
    localparam int DIR_ROWS    = 22;

    // unused mode code, handled like the stable mode
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // mode per random segment, segment 0 in the low bits
    localparam logic [2*NUM_SEGS-1:0] SEG_MODES = {
        MODE_LAST, MODE_FIRST_STABLE, MODE_FIRST_REV, MODE_LAST,
        MODE_SPARE, MODE_LAST, MODE_FIRST_STABLE, MODE_FIRST_REV
    };

    // one partitioned element as it shows on the result ports
    typedef struct packed {
        logic [DATA_W-1:0] elem;
        logic              eor;
        logic              ovf;
    } part_res_t;

    // one row of the directed request table
    typedef struct packed {
        logic              cfg_wr;
        logic [MODE_W-1:0] mode;
        logic [DATA_W-1:0] elem;
        logic              last;
        logic              pinned;
        logic [DATA_W-1:0] pin_elem;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [DATA_W-1:0] value;
    logic              is_last;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [MODE_W-1:0] partition_mode;
    logic              result_valid;
    logic [DATA_W-1:0] elem_out;
    logic              end_of_run;
    logic              overflow;

    // shadow of the block: loaded elements, count, drop flag and mode
    logic [DATA_W-1:0] load_store [STORE_DEPTH];
    int                load_cnt;
    logic              ovf_seen;
    logic [MODE_W-1:0] cur_mode;

    part_res_t         expected_elems [$];
    int                mismatches;
    int                cycle_cnt;

    // typed expectation for the request in flight, directed rows only
    logic              pin_active;
    logic [DATA_W-1:0] pin_elem;

    pivot_partition_engine #(
        .DEPTH(STORE_DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .value         (value),
        .is_last       (is_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .partition_mode(partition_mode),
        .result_valid  (result_valid),
        .elem_out      (elem_out),
        .end_of_run    (end_of_run),
        .overflow      (overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic part_res_t as_res(input logic [DATA_W-1:0] v);
        as_res = {v, 1'b0, ovf_seen};
    endfunction

    // store one accepted element; on the last one queue the partitioned run
    task automatic load_and_partition(input logic [DATA_W-1:0] v, input logic l);
        part_res_t         run_buf [STORE_DEPTH];
        logic [DATA_W-1:0] pivot;
        int                k;
        int                i;
        int                n;
        k = 0;
        // a full store drops the element, the last one included
        if (load_cnt < STORE_DEPTH)
        begin
            load_store[load_cnt] = v;
            load_cnt++;
        end
        else
        begin
            ovf_seen = 1'b1;
        end
        if (l)
        begin
            n = load_cnt;
            if (n <= 1)
            begin
                // single element passes straight through
                run_buf[0] = as_res(load_store[0]);
                k = 1;
            end
            else if (cur_mode == MODE_FIRST_REV)
            begin
                // smaller part walked backward, then pivot and the rest
                pivot = load_store[0];
                for (i = n - 1; i >= 1; i--)
                begin
                    if (load_store[i] < pivot)
                    begin
                        run_buf[k] = as_res(load_store[i]);
                        k = k + 1;
                    end
                end
                run_buf[k] = as_res(pivot);
                k = k + 1;
                for (i = 1; i < n; i++)
                begin
                    if (load_store[i] >= pivot)
                    begin
                        run_buf[k] = as_res(load_store[i]);
                        k = k + 1;
                    end
                end
            end
            else if (cur_mode == MODE_LAST)
            begin
                // pivot is the last stored element, not the last offered
                pivot = load_store[n - 1];
                for (i = 0; i < n - 1; i++)
                begin
                    if (load_store[i] < pivot)
                    begin
                        run_buf[k] = as_res(load_store[i]);
                        k = k + 1;
                    end
                end
                run_buf[k] = as_res(pivot);
                k = k + 1;
                for (i = 0; i < n - 1; i++)
                begin
                    if (load_store[i] >= pivot)
                    begin
                        run_buf[k] = as_res(load_store[i]);
                        k = k + 1;
                    end
                end
            end
            else
            begin
                // stable split, also taken by the spare code
                pivot = load_store[0];
                for (i = 0; i < n; i++)
                begin
                    if (load_store[i] < pivot)
                    begin
                        run_buf[k] = as_res(load_store[i]);
                        k = k + 1;
                    end
                end
                for (i = 0; i < n; i++)
                begin
                    if (load_store[i] >= pivot)
                    begin
                        run_buf[k] = as_res(load_store[i]);
                        k = k + 1;
                    end
                end
            end
            run_buf[k - 1] = {run_buf[k - 1].elem, 1'b1, run_buf[k - 1].ovf};
            if (pin_active)
            begin
                run_buf[0] = {pin_elem, 1'b1, 1'b0};
                k = 1;
            end
            for (i = 0; i < k; i++)
            begin
                expected_elems.push_back(run_buf[i]);
            end
            load_cnt = 0;
            ovf_seen = 1'b0;
        end
    endtask

    // everything sampled here sees the values from before the edge
    always @(posedge clk)
    begin : watch
        part_res_t got;
        part_res_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                cur_mode = partition_mode;
            end
            if (start && !busy)
            begin
                load_and_partition(value, is_last);
            end
            if (result_valid)
            begin
                got = {elem_out, end_of_run, overflow};
                if (expected_elems.size() == 0)
                begin
                    $display("%0t: unexpected element expected none got %02h eor %0b ovf %0b",
                             $time, got.elem, got.eor, got.ovf);
                    mismatches++;
                end
                else
                begin
                    want = expected_elems.pop_front();
                    if (got.elem !== want.elem)
                    begin
                        $display("%0t: elem_out expected %02h got %02h",
                                 $time, want.elem, got.elem);
                    end
                    if (got.eor !== want.eor)
                    begin
                        $display("%0t: end_of_run expected %0b got %0b",
                                 $time, want.eor, got.eor);
                    end
                    if (got.ovf !== want.ovf)
                    begin
                        $display("%0t: overflow expected %0b got %0b",
                                 $time, want.ovf, got.ovf);
                    end
                    if (got !== want)
                    begin
                        mismatches++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // offer one request and hold it until the block takes it
    task automatic send_elem(input logic [DATA_W-1:0] v, input logic l,
                             input logic pin, input logic [DATA_W-1:0] pin_v);
        @(negedge clk);
        start      = 1'b1;
        value      = v;
        is_last    = l;
        pin_active = pin;
        pin_elem   = pin_v;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    // a pause with no request, junk on the data lines
    task automatic sender_gap();
        @(negedge clk);
        start   = 1'b0;
        value   = DATA_W'($urandom);
        is_last = 1'($urandom);
    endtask

    // mode write only once the block is quiet and every result is in
    task automatic write_mode(input logic [MODE_W-1:0] m);
        @(negedge clk);
        start = 1'b0;
        while (expected_elems.size() != 0 || busy)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
        cfg_valid      = 1'b1;
        partition_mode = m;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // directed requests: extremes, every mode, mode switch inside a run
    function automatic dir_row_t dir_row(input int idx);
        case (idx)
            // single elements right after reset, mode at its reset value
            0:  dir_row = {1'b0, MODE_FIRST_REV,    8'h00, 1'b0 | 1'b1, 1'b1, 8'h00};
            1:  dir_row = {1'b0, MODE_FIRST_REV,    8'hff, 1'b1, 1'b1, 8'hff};
            // reversed low part
            2:  dir_row = {1'b0, MODE_FIRST_REV,    8'h55, 1'b0, 1'b0, 8'h00};
            3:  dir_row = {1'b0, MODE_FIRST_REV,    8'haa, 1'b0, 1'b0, 8'h00};
            4:  dir_row = {1'b0, MODE_FIRST_REV,    8'h00, 1'b0, 1'b0, 8'h00};
            5:  dir_row = {1'b0, MODE_FIRST_REV,    8'h55, 1'b1, 1'b0, 8'h00};
            // stable split
            6:  dir_row = {1'b1, MODE_FIRST_STABLE, 8'h55, 1'b0, 1'b0, 8'h00};
            7:  dir_row = {1'b0, MODE_FIRST_STABLE, 8'haa, 1'b0, 1'b0, 8'h00};
            8:  dir_row = {1'b0, MODE_FIRST_STABLE, 8'h00, 1'b0, 1'b0, 8'h00};
            9:  dir_row = {1'b0, MODE_FIRST_STABLE, 8'h55, 1'b1, 1'b0, 8'h00};
            // last element as pivot
            10: dir_row = {1'b1, MODE_LAST,         8'haa, 1'b0, 1'b0, 8'h00};
            11: dir_row = {1'b0, MODE_LAST,         8'h00, 1'b0, 1'b0, 8'h00};
            12: dir_row = {1'b0, MODE_LAST,         8'hff, 1'b0, 1'b0, 8'h00};
            13: dir_row = {1'b0, MODE_LAST,         8'h55, 1'b1, 1'b0, 8'h00};
            // spare mode code
            14: dir_row = {1'b1, MODE_SPARE,        8'h55, 1'b0, 1'b0, 8'h00};
            15: dir_row = {1'b0, MODE_SPARE,        8'haa, 1'b0, 1'b0, 8'h00};
            16: dir_row = {1'b0, MODE_SPARE,        8'h00, 1'b0, 1'b0, 8'h00};
            17: dir_row = {1'b0, MODE_SPARE,        8'h55, 1'b1, 1'b0, 8'h00};
            // mode switched between loading and the last request
            18: dir_row = {1'b1, MODE_FIRST_REV,    8'h10, 1'b0, 1'b0, 8'h00};
            19: dir_row = {1'b0, MODE_FIRST_REV,    8'h20, 1'b0, 1'b0, 8'h00};
            20: dir_row = {1'b1, MODE_LAST,         8'h05, 1'b1, 1'b0, 8'h00};
            // single element under the last-pivot mode
            21: dir_row = {1'b0, MODE_LAST,         8'h7f, 1'b1, 1'b1, 8'h7f};
            default: dir_row = '0;
        endcase
    endfunction

    initial
    begin : stimulus
        dir_row_t          row;
        int                r;
        int                seg;
        int                seg_cnt;
        int                len;
        int                j;
        int                gap_pct;
        int                drain;
        logic              narrow;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] v;

        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        value          = '0;
        is_last        = 1'b0;
        cfg_valid      = 1'b0;
        partition_mode = MODE_FIRST_REV;
        pin_active     = 1'b0;
        pin_elem       = '0;
        load_cnt       = 0;
        ovf_seen       = 1'b0;
        cur_mode       = MODE_FIRST_REV;
        mismatches     = 0;
        cycle_cnt      = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table, back to back
        for (r = 0; r < DIR_ROWS; r++)
        begin
            row = dir_row(r);
            if (row.cfg_wr)
            begin
                write_mode(row.mode);
            end
            send_elem(row.elem, row.last, row.pinned, row.pin_elem);
        end

        // random runs; segments rotate mode and sender gap rate
        for (seg = 0; seg < NUM_SEGS; seg++)
        begin
            write_mode(SEG_MODES[2 * seg +: 2]);
            case (seg % 4)
                1:       gap_pct = 45;
                3:       gap_pct = 29;
                default: gap_pct = 0;
            endcase
            seg_cnt = 0;
            while (seg_cnt < SEG_ITEMS)
            begin
                if (seg_cnt == 0 && seg == 2)
                begin
                    // overflow with the last request dropped
                    len = STORE_DEPTH + 2;
                end
                else if (seg_cnt == 0 && seg == 5)
                begin
                    // around full: just below, exactly full, or a few dropped
                    len = $urandom_range(STORE_DEPTH - 1, STORE_DEPTH + 4);
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 15)
                        len = 1;
                    else if (r < 80)
                        len = $urandom_range(2, 8);
                    else
                        len = $urandom_range(9, 20);
                end
                // narrow runs crowd values around one spot so ties with the pivot show up
                narrow = 1'($urandom_range(0, 1));
                base   = DATA_W'($urandom_range(0, 252));
                for (j = 0; j < len; j++)
                begin
                    while ($urandom_range(1, 100) <= gap_pct)
                    begin
                        sender_gap();
                    end
                    if (narrow)
                        v = DATA_W'(base + $urandom_range(0, 3));
                    else
                        v = DATA_W'($urandom_range(0, 255));
                    send_elem(v, j == len - 1, 1'b0, 8'h00);
                end
                seg_cnt += len;
            end
        end

        // drain, then a short tail for stray strobes
        @(negedge clk);
        start = 1'b0;
        drain = 0;
        while (expected_elems.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (8) @(negedge clk);
        if (expected_elems.size() != 0)
        begin
            $display("%0t: %0d expected elements never arrived", $time,
                     expected_elems.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
